FILE: design/lgg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_pkg: shared types and constants of the life grid generation block
// Grid size, field widths, function codes and sequencer states.
// ----------------------------------------------------------------------------
package lgg_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int FuncW  = 2;
  localparam int RowW   = 6;
  localparam int CellsW = 64;
  localparam int GenW   = 32;

  localparam int AddrW  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  localparam logic [FuncW-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_ADVANCE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ADV_FIRST,
    ST_ADV_ROW
  } state_e;

  typedef logic [GRID_WIDTH-1:0] grid_row_t;

endpackage

FILE: design/lgg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_in_if: command channel
// Valid/ready channel carrying one command word: func, row and cells_in.
// ----------------------------------------------------------------------------
interface lgg_in_if;
  logic                       valid;
  logic                       ready;
  logic [lgg_pkg::FuncW-1:0]  func;
  logic [lgg_pkg::RowW-1:0]   row;
  logic [lgg_pkg::CellsW-1:0] cells_in;

  modport source (output valid, output func, output row, output cells_in, input ready);
  modport sink   (input valid, input func, input row, input cells_in, output ready);
endinterface

FILE: design/lgg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_out_if: result channel
// Valid/ready channel carrying one result word: cells_out and generation.
// ----------------------------------------------------------------------------
interface lgg_out_if;
  logic                       valid;
  logic                       ready;
  logic [lgg_pkg::CellsW-1:0] cells_out;
  logic [lgg_pkg::GenW-1:0]   generation;

  modport source (output valid, output cells_out, output generation, input ready);
  modport sink   (input valid, input cells_out, input generation, output ready);
endinterface

FILE: design/life_grid_generation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation: Game of Life grid with row access and generation step
// Row grid in a RAM, one shared row-rule unit stepped over all rows by a
// small sequencer, one result word per command word.
// ----------------------------------------------------------------------------
//   channel  dir  modport  payload
//   in_i     in   sink     func, row, cells_in
//   out_o    out  source   cells_out, generation
//
// Write and out-of-range or unused commands: result registered in the cycle after accept.
// Read: one RAM read, then the result register.
// Advance: ST_ADV_FIRST, then ST_ADV_ROW over every row, one row through the RAM port per cycle.
// Reset clears row valid bits, so every row reads as dead; no clearing pass.
// in_i.ready is low while a read or advance runs or a result is stalled.
// ----------------------------------------------------------------------------
module life_grid_generation (
  input  logic       clk_i,
  input  logic       rst_ni,
  lgg_in_if.sink     in_i,
  lgg_out_if.source  out_o
);

  localparam int H  = lgg_pkg::GRID_HEIGHT;
  localparam int AW = lgg_pkg::AddrW;

  lgg_pkg::state_e            state_q, state_d;
  logic [AW-1:0]              cnt_q, cnt_d;
  logic [lgg_pkg::GenW-1:0]   gen_q, gen_d;
  lgg_pkg::grid_row_t         above_q, above_d;
  lgg_pkg::grid_row_t         cur_q, cur_d;
  logic [H-1:0]               valid_q, valid_d;
  logic                       rd_ok_q;
  logic                       out_valid_q, out_valid_d;
  logic [lgg_pkg::CellsW-1:0] cells_q, cells_d;
  logic [lgg_pkg::GenW-1:0]   ogen_q, ogen_d;

  logic                       accept;
  logic                       in_range;
  logic                       last_row;
  logic [AW:0]                nxt2;
  logic [AW-1:0]              in_addr;
  lgg_pkg::grid_row_t         wdata_in;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  lgg_pkg::grid_row_t         ram_wdata, ram_rdata;
  lgg_pkg::grid_row_t         rd_row, below, next_row;

  assign in_i.ready      = (state_q == lgg_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept          = in_i.valid && in_i.ready;
  assign in_range        = 32'(in_i.row) < 32'(H);
  assign in_addr         = AW'(in_i.row);
  assign wdata_in        = in_i.cells_in[lgg_pkg::GRID_WIDTH-1:0];
  assign last_row        = cnt_q == AW'(H - 1);
  assign nxt2            = {1'b0, cnt_q} + (AW+1)'(2);
  assign rd_row          = rd_ok_q ? ram_rdata : '0;
  assign below           = last_row ? '0 : rd_row;

  assign out_o.valid      = out_valid_q;
  assign out_o.cells_out  = cells_q;
  assign out_o.generation = ogen_q;

  lgg_ram #(
    .Width (lgg_pkg::GRID_WIDTH),
    .Depth (H)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lgg_row_unit u_rule (
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below),
    .next_o  (next_row)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgg_pkg::ST_IDLE: begin
        if (accept && in_range && (in_i.func == lgg_pkg::FUNC_READ)) begin
          state_d = lgg_pkg::ST_READ;
        end else if (accept && (in_i.func == lgg_pkg::FUNC_ADVANCE)) begin
          state_d = lgg_pkg::ST_ADV_FIRST;
        end
      end
      lgg_pkg::ST_READ:      state_d = lgg_pkg::ST_IDLE;
      lgg_pkg::ST_ADV_FIRST: state_d = lgg_pkg::ST_ADV_ROW;
      lgg_pkg::ST_ADV_ROW: begin
        if (last_row) begin
          state_d = lgg_pkg::ST_IDLE;
        end
      end
      default: state_d = lgg_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = in_addr;
    ram_wdata   = wdata_in;
    ram_re      = 1'b0;
    ram_raddr   = in_addr;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    above_d     = above_q;
    cur_d       = cur_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_o.ready;
    cells_d     = cells_q;
    ogen_d      = ogen_q;
    unique case (state_q)
      lgg_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_i.func == lgg_pkg::FUNC_ADVANCE) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            above_d   = '0;
          end else if (in_range && (in_i.func == lgg_pkg::FUNC_READ)) begin
            ram_re = 1'b1;
          end else begin
            // write, out-of-range row or unused code: answer now
            out_valid_d = 1'b1;
            ogen_d      = gen_q;
            cells_d     = '0;
            if (in_range && (in_i.func == lgg_pkg::FUNC_WRITE)) begin
              ram_we           = 1'b1;
              valid_d[in_addr] = 1'b1;
              cells_d          = lgg_pkg::CellsW'(wdata_in);
            end
          end
        end
      end
      lgg_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        cells_d     = lgg_pkg::CellsW'(rd_row);
        ogen_d      = gen_q;
      end
      lgg_pkg::ST_ADV_FIRST: begin
        cur_d     = rd_row;
        cnt_d     = '0;
        ram_re    = H > 1;
        ram_raddr = AW'(1);
      end
      lgg_pkg::ST_ADV_ROW: begin
        ram_we           = 1'b1;
        ram_waddr        = cnt_q;
        ram_wdata        = next_row;
        valid_d[cnt_q]   = 1'b1;
        above_d          = cur_q;
        cur_d            = below;
        ram_re           = nxt2 < (AW+1)'(H);
        ram_raddr        = AW'(nxt2);
        cnt_d            = cnt_q + AW'(1);
        if (last_row) begin
          gen_d       = gen_q + lgg_pkg::GenW'(1);
          out_valid_d = 1'b1;
          cells_d     = '0;
          ogen_d      = gen_q + lgg_pkg::GenW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgg_pkg::ST_IDLE;
      cnt_q       <= '0;
      gen_q       <= '0;
      valid_q     <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (ram_re) begin
        rd_ok_q <= valid_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    cur_q   <= cur_d;
    cells_q <= cells_d;
    ogen_q  <= ogen_d;
  end

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid RAM read and write hit the same row");

  a_gen_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgg_pkg::ST_ADV_ROW && last_row)
      |=> (gen_q == $past(gen_q) + lgg_pkg::GenW'(1)))
    else $error("generation count did not step at end of advance");

  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lgg_pkg::ST_IDLE) |-> !in_i.ready)
    else $error("command accepted while sequencer busy");

  a_read_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgg_pkg::ST_READ) |-> $past(accept))
    else $error("read state entered without a command");

endmodule

FILE: design/lgg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lgg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/lgg_row_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_row_unit: next-generation rule for one grid row
// Counts the eight neighbours of every column (columns wrap) and applies B3/S23.
// ----------------------------------------------------------------------------
module lgg_row_unit (
  input  lgg_pkg::grid_row_t above_i,
  input  lgg_pkg::grid_row_t cur_i,
  input  lgg_pkg::grid_row_t below_i,
  output lgg_pkg::grid_row_t next_o
);

  localparam int W = lgg_pkg::GRID_WIDTH;

  always_comb begin
    int       lc;
    int       rc;
    logic [3:0] n;
    next_o = '0;
    for (int c = 0; c < W; c++) begin
      lc = (c == 0) ? W - 1 : c - 1;
      rc = (c == W - 1) ? 0 : c + 1;
      n  = 4'(above_i[lc]) + 4'(above_i[c]) + 4'(above_i[rc])
         + 4'(cur_i[lc]) + 4'(cur_i[rc])
         + 4'(below_i[lc]) + 4'(below_i[c]) + 4'(below_i[rc]);
      next_o[c] = (n == 4'd3) || (cur_i[c] && (n == 4'd2));
    end
  end

endmodule

FILE: bench/life_grid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_checker: result checker for the life grid generation block
// Watches the command and result channels and keeps its own copy of the
// grid and the generation count. Every accepted command word yields one
// expected result word. Each accepted result word is compared field by field
// with the oldest one still due. Reports the mismatch count and the number of
// result words still due.
// ----------------------------------------------------------------------------
module life_grid_checker
  import lgg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lgg_in_if    cmd_if,
  lgg_out_if   res_if,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic [CellsW-1:0] cells;
    logic [GenW-1:0]   gen;
  } life_result_t;

  grid_row_t    life_grid [GRID_HEIGHT];
  logic [GenW-1:0] gen_count;
  life_result_t due_results [$];
  life_result_t want;
  int           mismatches;

  function automatic grid_row_t evolve_row(grid_row_t up, grid_row_t mid, grid_row_t dn);
    grid_row_t nxt;
    int        lc;
    int        rc;
    int        n;
    nxt = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      lc = (c == 0) ? GRID_WIDTH - 1 : c - 1;
      rc = (c == GRID_WIDTH - 1) ? 0 : c + 1;
      n = int'(up[lc]) + int'(up[c]) + int'(up[rc])
        + int'(mid[lc]) + int'(mid[rc])
        + int'(dn[lc]) + int'(dn[c]) + int'(dn[rc]);
      if (n == 3 || (mid[c] && n == 2)) nxt[c] = 1'b1;
    end
    return nxt;
  endfunction

  function automatic void advance_grid();
    grid_row_t prev;
    grid_row_t cur;
    grid_row_t below;
    prev = '0;
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      cur = life_grid[r];
      below = (r + 1 < GRID_HEIGHT) ? life_grid[r + 1] : '0;
      life_grid[r] = evolve_row(prev, cur, below);
      prev = cur;
    end
    gen_count = gen_count + GenW'(1);
  endfunction

  function automatic life_result_t run_command(logic [FuncW-1:0] fn, logic [RowW-1:0] r,
                                               logic [CellsW-1:0] cells);
    life_result_t res;
    res.cells = '0;
    case (fn)
      FUNC_WRITE: begin
        if (r < GRID_HEIGHT) begin
          life_grid[r] = cells[GRID_WIDTH-1:0];
          res.cells = CellsW'(life_grid[r]);
        end
      end
      FUNC_READ: begin
        if (r < GRID_HEIGHT) res.cells = CellsW'(life_grid[r]);
      end
      FUNC_ADVANCE: begin
        advance_grid();
      end
      default: begin
      end
    endcase
    res.gen = gen_count;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_HEIGHT; r++) life_grid[r] = '0;
      gen_count = '0;
      due_results.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word: cells_out=%h generation=%0d",
                 res_if.cells_out, res_if.generation);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (res_if.cells_out !== want.cells) begin
            $error("cells_out mismatch: expected %h, actual %h", want.cells, res_if.cells_out);
            mismatches++;
          end
          if (res_if.generation !== want.gen) begin
            $error("generation mismatch: expected %0d, actual %0d", want.gen,
                   res_if.generation);
            mismatches++;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        due_results.push_back(run_command(cmd_if.func, cmd_if.row, cmd_if.cells_in));
      errors_o <= mismatches;
      pending_o <= due_results.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top of the life grid generation block
// Drives directed command words (grid edges, column wrap, all functions, the
// unused code) and then random episodes of row writes, reads, unused-code words and
// generation steps, with random idle bursts on both channels. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import lgg_pkg::*;

  localparam logic [FuncW-1:0] FUNC_NONE = 2'd3;
  localparam int ITEM_TARGET = 1300;
  localparam int CALM_AFTER  = 1150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   idle_on = 1'b0;
  int   stall_left = 0;
  int   sent = 0;
  int   fail_count;
  int   words_pending;

  lgg_in_if  cmd_if ();
  lgg_out_if res_if ();

  life_grid_generation i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  life_grid_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_if    (cmd_if),
    .res_if    (res_if),
    .errors_o  (fail_count),
    .pending_o (words_pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("FAIL life_grid_generation");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  function automatic logic [CellsW-1:0] random_cells();
    logic [CellsW-1:0] a;
    logic [CellsW-1:0] b;
    logic [CellsW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return a & b & c;
      4, 5:    return a & b;
      6, 7:    return a;
      default: return a | b;
    endcase
  endfunction

  task automatic send_word(input logic [FuncW-1:0] fn, input logic [RowW-1:0] r,
                           input logic [CellsW-1:0] cells);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.func     <= fn;
    cmd_if.row      <= r;
    cmd_if.cells_in <= cells;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent++;
  endtask

  task automatic run_episode();
    int base;
    int span;
    int pick;
    int steps;
    base = $urandom_range(0, GRID_HEIGHT - 1);
    span = $urandom_range(3, 24);
    idle_on <= (sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
    for (int k = 0; k < span; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_word(FUNC_NONE, RowW'($urandom_range(0, GRID_HEIGHT - 1)), random_cells());
      else if (pick < 3)
        send_word(FUNC_READ, RowW'($urandom_range(0, GRID_HEIGHT - 1)), random_cells());
      else
        send_word(FUNC_WRITE, RowW'((base + k) % GRID_HEIGHT), random_cells());
    end
    steps = $urandom_range(1, 6);
    for (int s = 0; s < steps; s++) begin
      send_word(FUNC_ADVANCE, RowW'($urandom), random_cells());
      repeat ($urandom_range(1, 3))
        send_word(FUNC_READ, RowW'((base + $urandom_range(0, span + 1)) % GRID_HEIGHT),
                  random_cells());
    end
  endtask

  initial begin
    cmd_if.valid    <= 1'b0;
    cmd_if.func     <= FUNC_WRITE;
    cmd_if.row      <= '0;
    cmd_if.cells_in <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on <= 1'b1;

    send_word(FUNC_READ, 6'd5, '1);
    send_word(FUNC_NONE, 6'd63, '1);
    send_word(FUNC_WRITE, 6'd0, '1);
    send_word(FUNC_WRITE, 6'd63, '1);
    send_word(FUNC_READ, 6'd0, '0);
    send_word(FUNC_READ, 6'd63, '0);
    send_word(FUNC_WRITE, 6'd0, '0);
    send_word(FUNC_WRITE, 6'd20, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(FUNC_WRITE, 6'd21, 64'h5555_5555_5555_5555);
    send_word(FUNC_WRITE, 6'd10, 64'h8000_0000_0000_0003);
    send_word(FUNC_WRITE, 6'd40, 64'h8000_0000_0000_0000);
    send_word(FUNC_WRITE, 6'd41, 64'h0000_0000_0000_0001);
    send_word(FUNC_WRITE, 6'd42, 64'hC000_0000_0000_0001);
    send_word(FUNC_ADVANCE, 6'd0, '0);
    send_word(FUNC_READ, 6'd62, '0);
    send_word(FUNC_READ, 6'd63, '0);
    send_word(FUNC_READ, 6'd10, '0);
    send_word(FUNC_READ, 6'd9, '0);
    send_word(FUNC_ADVANCE, 6'd63, '1);
    send_word(FUNC_READ, 6'd41, '0);
    send_word(FUNC_READ, 6'd20, '0);
    send_word(FUNC_NONE, 6'd0, random_cells());
    send_word(FUNC_READ, 6'd11, '0);

    while (sent < ITEM_TARGET) run_episode();

    cmd_if.valid <= 1'b0;
    idle_on <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS life_grid_generation");
    else
      $display("FAIL life_grid_generation");
    $finish;
  end

endmodule

FILE: sim.f
design/lgg_pkg.sv
design/lgg_in_if.sv
design/lgg_out_if.sv
design/lgg_ram.sv
design/lgg_row_unit.sv
design/life_grid_generation.sv
bench/life_grid_checker.sv
bench/tb_top.sv
